### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/swm_pkg.sv
// Package: types and constants of the sliding window maximum block.
`timescale 1ns / 1ps
package swm_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]         width_t;

  localparam width_t  WIDTH_RESET = width_t'(3);
  localparam sample_t SAMPLE_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

### hw/rtl/sliding_window_maximum.sv
// Top level: sliding window maximum over a chain of max cells.
`timescale 1ns / 1ps
// Path: each result passes the pending slot, then the output register (out_valid).
// Throughput: one item per cycle unless stalled; one compare per cell per item.
// Backpressure: in_ready drops only while a result waits and another is pending.
// Reset (rst_n low, synchronous): clears the sample count, the pipeline valids
// and sets the window width to 3. The chain needs no clearing pass.
module sliding_window_maximum
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  input  logic    in_array_end,
  output logic    out_valid,
  input  logic    out_ready,
  output sample_t out_window_max,
  output logic    out_final_result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  width_t  cfg_window_width
);

  // Count saturates at MAX_WINDOW; cell index spans 0..MAX_WINDOW-1.
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  width_t             width_r;
  logic [CNT_W-1:0]   count_r, count_nxt, count_inc;
  logic               pend_v_r, pend_v_nxt;
  logic               pend_last_r;
  logic [IDX_W-1:0]   sel_r;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_max_r;
  logic               out_last_r;

  logic [EW-1:0]      width_ext, weff, cnt_ext, span;
  logic               accept, pend_adv, emit;
  sample_t            chain [MAX_WINDOW];
  sample_t            taps  [MAX_WINDOW];
  sample_t            tap_or;

  // The single register is always writable; index-free port.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid) begin
      width_r <= cfg_window_width;
    end
  end

  // Pending result moves out when the output register is free or being taken.
  assign pend_adv = !out_valid_r || out_ready;
  assign in_ready = !pend_v_r || pend_adv;
  assign accept   = in_valid && in_ready;

  // Effective width: zero acts as one, anything above MAX_WINDOW is clamped.
  always_comb begin
    width_ext = EW'(width_r);
    if (width_ext == '0) begin
      weff = EW'(1);
    end else if (width_ext > EW'(MAX_WINDOW)) begin
      weff = EW'(MAX_WINDOW);
    end else begin
      weff = width_ext;
    end
  end

  // Samples of this array including the incoming one, saturating.
  assign count_inc = (count_r == CNT_W'(MAX_WINDOW)) ? count_r : count_r + 1'b1;
  assign cnt_ext   = EW'(count_inc);
  // Window span actually read: the whole array while it is shorter than the window.
  assign span      = (cnt_ext < weff) ? cnt_ext : weff;
  // Result once the window is full, or on the last sample of a short array.
  assign emit      = (cnt_ext >= weff) || in_array_end;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = in_array_end ? '0 : count_inc;
    end
  end

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (accept) begin
      pend_v_nxt = emit;
    end else if (pend_adv) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Hold which cell to read and the end flag with the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r       <= IDX_W'(span - 1'b1);
      pend_last_r <= in_array_end;
    end
  end

  // Cell i keeps the max of the last i+1 samples. Only cells below the
  // array's sample count are ever selected, so stale data from an earlier
  // array never reaches the output.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    sample_t prev;
    if (i == 0) begin : g_head
      assign prev = SAMPLE_MIN;
    end else begin : g_body
      assign prev = chain[i-1];
    end

    swm_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .sample   (in_sample),
      .prev_max (prev),
      .sel      (sel_r),
      .cell_max (chain[i]),
      .tap      (taps[i])
    );
  end

  // At most one cell drives a nonzero tap; combine them.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  // Output register: load from the pending slot, drop on handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pend_adv) begin
      out_valid_nxt = pend_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv && pend_v_r) begin
      out_max_r  <= tap_or;
      out_last_r <= pend_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_max   = out_max_r;
  assign out_final_result = out_last_r;

endmodule

### hw/rtl/swm_cell.sv
// One cell of the max chain: holds the maximum of the last INDEX+1 samples.
`timescale 1ns / 1ps
module swm_cell
  import swm_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             shift_en,
  input  sample_t          sample,
  input  sample_t          prev_max,
  input  logic [IDX_W-1:0] sel,
  output sample_t          cell_max,
  output sample_t          tap
);

  sample_t max_r;

  // Advance: new sample against the neighbor's shorter-window maximum.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      max_r <= (sample > prev_max) ? sample : prev_max;
    end
  end

  assign cell_max = max_r;
  assign tap      = (sel == IDX_W'(INDEX)) ? max_r : '0;

endmodule

### hw/rtl/swm_checker.sv
// Checker for the sliding window maximum ports, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module swm_checker
  import swm_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_window_max,
  input logic    out_final_result,
  input logic    cfg_valid,
  input logic    cfg_ready
);

  // A stalled result keeps its payload.
  `SWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_window_max) && $stable(out_final_result))

  // Input stalls only when a result is stuck at the output.
  `SWM_ASSERT_SAME(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

  // A fresh result follows an accepted item, by way of the pending slot.
  `SWM_ASSERT_SAME(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

  // The width register is always writable.
  `SWM_ASSERT_SAME(a_cfg_open, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

### tb/sliding_window_maximum_tb.sv
// Testbench for the sliding window maximum block: scoreboard, stimulus and checks.
`timescale 1ns / 1ps
module sliding_window_maximum_tb;
  import swm_pkg::*;

  localparam int      DEPTH       = MAX_WINDOW_DEF;
  localparam int      QUIET_LIMIT = 5000;  // cycles without any handshake
  localparam int      HOLD_CYCLES = 200;   // long receiver hold-off
  localparam sample_t SAMPLE_MAX  = {1'b0, {(DATA_W-1){1'b1}}};

  // One expected result: the window maximum and the end-of-array mark.
  typedef struct packed {
    sample_t window_max;
    logic    final_flag;
  } max_result_t;

  // Scoreboard: tracks the window, the per-array count and running maximum,
  // and the queue of results the block still owes us.
  class window_max_scoreboard;
    width_t      width_reg;
    sample_t     recent[DEPTH];
    int          seen;
    sample_t     array_max;
    int          errors;
    max_result_t expected_results[$];

    function new();
      width_reg = WIDTH_RESET;
      foreach (recent[k]) recent[k] = '0;
      seen      = 0;
      array_max = SAMPLE_MIN;
      errors    = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Advance the window by one accepted sample and queue the result it causes.
    function void note_sample(sample_t s, logic last_in);
      int          w;
      int          k;
      sample_t     m;
      max_result_t r;
      w = width_reg;
      if (w == 0) w = 1;             // a zero width behaves as one
      if (w > DEPTH) w = DEPTH;      // clamp oversize widths
      for (k = DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = s;
      if (seen < DEPTH) seen++;
      if (s > array_max || seen == 1) array_max = s;
      if (seen >= w) begin
        m = recent[0];
        for (k = 1; k < w; k++)
          if (recent[k] > m) m = recent[k];
        r.window_max = m;
        r.final_flag = last_in;
        expected_results = {expected_results, r};
      end else if (last_in) begin
        // short array: one result, the maximum of everything seen
        r.window_max = array_max;
        r.final_flag = 1'b1;
        expected_results = {expected_results, r};
      end
      if (last_in) begin
        seen      = 0;
        array_max = SAMPLE_MIN;
      end
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_result(sample_t got_max, logic got_final);
      max_result_t r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got max %0d final %0b",
                 $time, got_max, got_final);
        errors++;
        return;
      end
      r = expected_results.pop_front();
      if (got_max !== r.window_max) begin
        $display("%0t: window_max mismatch, expected %0d, got %0d",
                 $time, r.window_max, got_max);
        errors++;
      end
      if (got_final !== r.final_flag) begin
        $display("%0t: final_result mismatch, expected %0b, got %0b",
                 $time, r.final_flag, got_final);
        errors++;
      end
    endfunction
  endclass

  // Drive every input to a known value from time zero; hold reset low.
  logic    clk              = 1'b0;
  logic    rst_n            = 1'b0;
  logic    in_valid         = 1'b0;
  logic    in_ready;
  sample_t in_sample        = '0;
  logic    in_array_end     = 1'b0;
  logic    out_valid;
  logic    out_ready        = 1'b0;
  sample_t out_window_max;
  logic    out_final_result;
  logic    cfg_valid        = 1'b0;
  logic    cfg_ready;
  width_t  cfg_window_width = WIDTH_RESET;

  window_max_scoreboard sb = new();

  // Idle knobs, in percent of cycles, changed per phase by the main sequence.
  int     gap_pct      = 0;
  int     stall_pct    = 0;
  bit     hold_request = 1'b0;
  int     hold_left    = 0;
  int     quiet_cycles = 0;
  width_t cur_width    = WIDTH_RESET;
  sample_t prev_sample = '0;

  always #4 clk = ~clk;

  sliding_window_maximum dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_array_end     (in_array_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_max   (out_window_max),
    .out_final_result (out_final_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_width (cfg_window_width)
  );

  // Receiver: check every accepted result, then pick out_ready for the next
  // cycle. A hold-off request drops ready for a long stretch, counted here,
  // so the block fills up and pushes back on its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_window_max, out_final_result);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted.
  // Lower valid only during a gap, so it is never dropped and raised in one step.
  task automatic send_item(sample_t s, logic last_in);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_array_end <= last_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s, last_in);
  endtask

  // Stop offering items and wait until every expected result has arrived,
  // then let the pipeline settle in case the last item caused no result.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the window width; the block must be idle here.
  task automatic write_width(width_t w);
    cfg_valid        <= 1'b1;
    cfg_window_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.width_reg = w;
    cur_width    = w;
    cfg_valid    <= 1'b0;
  endtask

  // Send arrays of random length and content. Lengths cluster around the
  // window width: single samples, exact-width arrays, short ones and long
  // ones that slide the window and saturate the count. An array cut off at
  // the end of the phase carries over into the next width.
  task automatic send_arrays(int n_items);
    int      sent;
    int      len;
    int      k;
    int      w;
    sample_t s;
    sent = 0;
    w = cur_width;
    if (w == 0) w = 1;
    if (w > DEPTH) w = DEPTH;
    while (sent < n_items) begin
      case ($urandom_range(7))
        0:       len = 1;
        1:       len = w;
        2:       len = (w > 1) ? w - 1 : 1;
        3, 4:    len = $urandom_range(w, 1);
        default: len = $urandom_range(2 * w + 4, w);
      endcase
      for (k = 0; k < len && sent < n_items; k++) begin
        case ($urandom_range(9))
          0:       s = SAMPLE_MIN;
          1:       s = SAMPLE_MAX;
          2:       s = sample_t'(int'($urandom_range(20)) - 10);
          3, 4:    s = prev_sample - sample_t'($urandom_range(3));  // falling run
          default: s = sample_t'($urandom);
        endcase
        prev_sample = s;
        send_item(s, k == len - 1);
        sent++;
      end
    end
  endtask

  // One random phase: set width and idling, optionally squeeze the receiver.
  task automatic run_phase(width_t w, int sender_idle, int recv_stall, int n_items,
                           bit squeeze);
    gap_pct   = sender_idle;
    stall_pct = recv_stall;
    write_width(w);
    if (squeeze) hold_request = 1'b1;
    send_arrays(n_items);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset width of three, no idling.
    send_item(SAMPLE_MAX, 1'b0);     // array exactly as long as the window
    send_item(SAMPLE_MIN, 1'b0);
    send_item('0, 1'b1);
    send_item(SAMPLE_MIN, 1'b1);     // one-sample array
    send_item(-1, 1'b0);             // short array of two
    send_item(1, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);     // slide: let the maximum fall out
    send_item(SAMPLE_MAX, 1'b0);
    send_item(5, 1'b0);
    send_item(-5, 1'b0);
    send_item(-7, 1'b0);
    send_item(-9, 1'b1);
    drain();
    write_width('0);                 // zero width behaves as one
    send_item(7, 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
    drain();
    write_width('1);                 // oversize width clamps to the maximum
    send_item(3, 1'b0);
    send_item(-4, 1'b1);
    drain();
    write_width(width_t'(2));        // start an array, then widen it midway
    send_item(10, 1'b0);
    send_item(20, 1'b0);
    send_item(30, 1'b0);
    drain();
    write_width(width_t'(5));
    send_item(1, 1'b0);
    send_item(2, 1'b1);
    drain();

    // Random phases across widths and idling patterns.
    run_phase(width_t'(1),   0,  0,  150, 1'b1);  // receiver held off, input backs up
    run_phase(width_t'(DEPTH), 0,  0,  400, 1'b0);
    run_phase('0,            82, 0,  200, 1'b0);
    run_phase('1,            0,  82, 300, 1'b0);
    run_phase(width_t'(5),   21, 21, 250, 1'b0);
    run_phase(width_t'($urandom_range(127)), 0, 82, 200, 1'b0);
    run_phase(width_t'(2),   82, 0,  200, 1'b0);
    run_phase(width_t'($urandom_range(16, 1)), 21, 21, 250, 1'b0);

    // Catch any stray result after the last expectation.
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
